FILE: rtl/core/random_subset_sampler_top_defines.svh
// Assertion macros shared by the checker of the random subset sampler.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RANDOM_SUBSET_SAMPLER_TOP_DEFINES_SVH
`define RANDOM_SUBSET_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rss_pkg.sv
// Package of the random subset sampler: sizes, register indexes, command codes
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

  localparam int POP_MAX    = 256;
  localparam int POP_LIMIT  = 256;
  localparam int ADDR_W     = $clog2(POP_MAX);
  localparam int IDX_W      = 8;
  localparam int POP_W      = 9;
  localparam int SUB_W      = 8;
  localparam int WORD_W     = 32;
  localparam int BITCNT_W   = $clog2(WORD_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 1'b1;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic fill_step;  // write one store entry of the begin fill
    logic div_step;   // one restoring step of the remainder
    logic rd_j;       // read entry j, hold old entry i
    logic sw_i;       // write entry i with old entry j
    logic sw_j;       // write entry j with old entry i
    logic emit;       // move the pending result into the output register
  } rss_cmd_t;

  typedef struct packed {
    logic item_err;   // the offered item would be refused
    logic is_draw;    // the offered item is a draw
    logic fill_done;  // last store entry is being written
    logic div_done;   // last remainder step
    logic out_free;   // output register can take a result this cycle
  } rss_stat_t;

endpackage

FILE: rtl/core/rss_ctrl.sv
// Controller state machine of the random subset sampler.
// Depends on rss_pkg for the command and status structs.
`timescale 1ns / 1ps

module rss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rss_pkg::rss_stat_t stat,
  output rss_pkg::rss_cmd_t  cmd
);
  import rss_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FILL = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_RD_J = 7'b0001000,
    ST_SW_I = 7'b0010000,
    ST_SW_J = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          priority if (stat.item_err) begin
            state_nxt = ST_EMIT;
          end else if (stat.is_draw) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_RD_J;
        end
      end
      ST_RD_J: begin
        cmd.rd_j  = 1'b1;
        state_nxt = ST_SW_I;
      end
      ST_SW_I: begin
        cmd.sw_i  = 1'b1;
        state_nxt = ST_SW_J;
      end
      ST_SW_J: begin
        cmd.sw_j  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/rss_datapath.sv
// Datapath of the random subset sampler: configuration registers, index store,
// bit-serial remainder unit and output register. Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_cmd,
  input  logic [rss_pkg::IDX_W-1:0]      in_source_index,
  input  logic [rss_pkg::WORD_W-1:0]     in_random_word,
  input  rss_pkg::rss_cmd_t              cmd,
  output rss_pkg::rss_stat_t             stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [rss_pkg::IDX_W-1:0]      out_picked_index,
  output logic                           out_last,
  output logic                           out_error
);
  import rss_pkg::*;

  // Configuration and selection state.
  logic [POP_W-1:0]    pop_size_r;
  logic [SUB_W-1:0]    subset_size_r;
  logic [SUB_W-1:0]    draw_count_r;
  logic                active_r;

  // Begin fill.
  logic [IDX_W-1:0]    src_r;
  logic [IDX_W-1:0]    fill_n_r;

  // Remainder unit.
  logic [WORD_W-1:0]   word_r;
  logic [IDX_W-1:0]    rem_r, rem_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r;
  logic [POP_W-1:0]    div_r;
  logic [POP_W-1:0]    rem_sh;

  // Index store and swap.
  logic [IDX_W-1:0]    store_mem [POP_MAX];
  logic [IDX_W-1:0]    rdata_r;
  logic [IDX_W-1:0]    tmp_i_r;
  logic [ADDR_W-1:0]   raddr, waddr;
  logic [IDX_W-1:0]    wdata;
  logic                we;
  logic [IDX_W-1:0]    j_idx;
  logic [IDX_W-1:0]    fill_val;

  // Pending result and output register.
  logic [IDX_W-1:0]    res_idx_r;
  logic                res_last_r;
  logic                res_err_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;
  logic                out_err_r;

  logic                cfg_ok;
  logic [SUB_W-1:0]    count_inc;

  assign cfg_ok = (pop_size_r >= POP_W'(2)) && (pop_size_r <= POP_W'(POP_LIMIT)) &&
                  (int'(pop_size_r) <= POP_MAX) &&
                  ({1'b0, subset_size_r} < pop_size_r);

  assign stat.is_draw  = (in_cmd == CMD_DRAW);
  assign stat.item_err = stat.is_draw ?
                         (!cfg_ok || !active_r || (draw_count_r >= subset_size_r)) :
                         (!cfg_ok || ({1'b0, in_source_index} >= pop_size_r));
  assign stat.fill_done = ({1'b0, fill_n_r} == (pop_size_r - POP_W'(2)));
  assign stat.div_done  = (bit_cnt_r == BITCNT_W'(WORD_W - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r    <= POP_W'(POP_LIMIT);
      subset_size_r <= SUB_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POP_SIZE:    pop_size_r    <= cfg_wdata[POP_W-1:0];
        REG_SUBSET_SIZE: subset_size_r <= cfg_wdata[SUB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign count_inc = draw_count_r + SUB_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_count_r <= '0;
      active_r     <= 1'b0;
    end else if (cmd.accept && !stat.item_err && !stat.is_draw) begin
      draw_count_r <= '0;
      active_r     <= 1'b1;
    end else if (cmd.sw_j) begin
      draw_count_r <= count_inc;
    end
  end

  // Restoring remainder, one dividend bit per cycle, most significant first.
  assign rem_sh  = {rem_r, word_r[WORD_W-1]};
  assign rem_nxt = (rem_sh >= div_r) ? IDX_W'(rem_sh - div_r) : IDX_W'(rem_sh);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src_r     <= in_source_index;
      fill_n_r  <= '0;
      word_r    <= in_random_word;
      rem_r     <= '0;
      bit_cnt_r <= '0;
      div_r     <= pop_size_r - POP_W'(1) - POP_W'(draw_count_r);
    end else begin
      if (cmd.fill_step) begin
        fill_n_r <= fill_n_r + IDX_W'(1);
      end
      if (cmd.div_step) begin
        rem_r     <= rem_nxt;
        word_r    <= {word_r[WORD_W-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + BITCNT_W'(1);
      end
    end
  end

  assign j_idx    = IDX_W'({1'b0, draw_count_r} + {1'b0, rem_r});
  assign fill_val = (fill_n_r < src_r) ? fill_n_r : IDX_W'({1'b0, fill_n_r} + 9'd1);

  // Entry i is read throughout the remainder steps; entry j when rd_j is up.
  assign raddr = cmd.rd_j ? ADDR_W'(j_idx) : ADDR_W'(draw_count_r);
  assign we    = cmd.fill_step || cmd.sw_i || cmd.sw_j;

  always_comb begin
    priority if (cmd.fill_step) begin
      waddr = ADDR_W'(fill_n_r);
      wdata = fill_val;
    end else if (cmd.sw_i) begin
      waddr = ADDR_W'(draw_count_r);
      wdata = rdata_r;
    end else begin
      waddr = ADDR_W'(j_idx);
      wdata = tmp_i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= store_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_j) begin
      tmp_i_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_idx_r  <= '0;
      res_last_r <= 1'b0;
      res_err_r  <= stat.item_err;
    end else if (cmd.sw_i) begin
      res_idx_r  <= rdata_r;
      res_last_r <= (count_inc == subset_size_r);
      res_err_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= res_idx_r;
      out_last_r <= res_last_r;
      out_err_r  <= res_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_index = out_idx_r;
  assign out_last         = out_last_r;
  assign out_error        = out_err_r;

endmodule

FILE: rtl/core/random_subset_sampler_top.sv
// Top level of the random subset sampler (partial Fisher-Yates shuffle).
// Depends on rss_pkg, rss_ctrl and rss_datapath.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | cmd, source_index, random_word
//  out     | output    | out_valid / out_ready| picked_index, last, error
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// A draw item runs from the accepting cycle through the bit-serial remainder, one
// bit per cycle, the read of entry j and the two swap writes through the
// single-write-port index store, and the load into the output register.
// A begin item fills the index store, one store entry written per cycle.
// A refused item goes straight to the result load and leaves the store unchanged.
// Reset is synchronous and active low; the index store is not cleared.
// A stall on the output only holds the block once a new result is ready to load.

module random_subset_sampler_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [rss_pkg::IDX_W-1:0]      in_source_index,
  input  logic [rss_pkg::WORD_W-1:0]     in_random_word,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rss_pkg::IDX_W-1:0]      out_picked_index,
  output logic                           out_last,
  output logic                           out_error
);
  import rss_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  rss_cmd_t  cmd;
  rss_stat_t stat;

  // The controller sequences one item at a time: it accepts in its idle state,
  // then runs the fill, or the remainder steps and the swap, or goes straight
  // to the result load when the item is refused.
  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the index store, the remainder unit and
  // the output register, which lets the next item in while a result waits.
  rss_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_source_index  (in_source_index),
    .in_random_word   (in_random_word),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_picked_index (out_picked_index),
    .out_last         (out_last),
    .out_error        (out_error)
  );

endmodule

FILE: rtl/core/rss_checker.sv
// Port-level checker of the random subset sampler and its bind to the top level.
// Depends on rss_pkg and the assertion macros in random_subset_sampler_top_defines.svh.
`timescale 1ns / 1ps
`include "random_subset_sampler_top_defines.svh"

module rss_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rss_pkg::IDX_W-1:0] out_picked_index,
  input logic                      out_last,
  input logic                      out_error
);
  import rss_pkg::*;

  // A stalled result stays offered.
  `RSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `RSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_picked_index) && $stable(out_last) && $stable(out_error), "result payload changed while stalled")

  // A refused item reports no index and no last flag.
  `RSS_ASSERT_SAME(a_err_clean, out_valid && out_error, (out_picked_index == '0) && !out_last, "error result carries data")

  // Items are taken one at a time: ready drops right after an accept.
  `RSS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

bind random_subset_sampler_top rss_checker u_rss_checker (.*);
